>>> design/lavm_pkg.sv
// Shared types for the look-at view matrix block.
`timescale 1ns / 1ps

package lavm_pkg;

	// Port word of the input and output fields
	typedef logic [31:0] word_t;

	// One camera item as it travels from the front end to the core
	typedef struct packed {
		word_t [2:0] eye;
		word_t [2:0] gaze;
		word_t [2:0] up;
		logic        gaze_zero;
		logic        up_zero;
	} item_t;

	// Finished view matrix, m[column][row]
	typedef struct packed {
		logic                degenerate;
		word_t [3:0][3:0]    m;
	} matrix_t;

endpackage

>>> design/lavm_front.sv
// Front end: input register and zero-vector classification.
`timescale 1ns / 1ps

module lavm_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lavm_pkg::word_t       eye_x,
	input  lavm_pkg::word_t       eye_y,
	input  lavm_pkg::word_t       eye_z,
	input  lavm_pkg::word_t       gaze_x,
	input  lavm_pkg::word_t       gaze_y,
	input  lavm_pkg::word_t       gaze_z,
	input  lavm_pkg::word_t       up_x,
	input  lavm_pkg::word_t       up_y,
	input  lavm_pkg::word_t       up_z,
	output logic                  push,
	output lavm_pkg::item_t       push_item,
	input  logic                  q_full
);

	// Bits of a port word that carry the value
	localparam int LB = (WORD_BITS < 32) ? WORD_BITS : 32;

	logic            valid_s1;
	lavm_pkg::item_t item_s1;
	logic            take;

	function automatic logic is_zero3(input lavm_pkg::word_t a, input lavm_pkg::word_t b,
			input lavm_pkg::word_t c);
		return (a[LB-1:0] == '0) && (b[LB-1:0] == '0) && (c[LB-1:0] == '0);
	endfunction

	assign push      = valid_s1 && !q_full;
	assign in_stall  = valid_s1 && q_full;
	assign take      = in_valid && !in_stall;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.eye       <= {eye_z, eye_y, eye_x};
			item_s1.gaze      <= {gaze_z, gaze_y, gaze_x};
			item_s1.up        <= {up_z, up_y, up_x};
			item_s1.gaze_zero <= is_zero3(gaze_x, gaze_y, gaze_z);
			item_s1.up_zero   <= is_zero3(up_x, up_y, up_z);
		end
	end

endmodule

>>> design/lavm_fifo.sv
// Two-entry item queue between front end and core.
`timescale 1ns / 1ps

module lavm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lavm_pkg::item_t push_item,
	output logic            full,
	output logic            pop_valid,
	output lavm_pkg::item_t pop_item,
	input  logic            pop
);

	lavm_pkg::item_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_item  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

endmodule

>>> design/lavm_div.sv
// Restoring divider, two quotient bits a cycle, for unit-vector components.
`timescale 1ns / 1ps

module lavm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [60:0] num,
	input  logic [30:0] den,
	output logic        busy,
	output logic [30:0] quo
);

	logic [31:0] rem_q;
	logic [31:0] sh_q;
	logic [30:0] den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [31:0] rem_n;
	logic [31:0] sh_n;

	// Quotient fits 31 bits since the numerator's top part stays below den
	always_comb begin
		rem_n = rem_q;
		sh_n  = sh_q;
		for (int k = 0; k < 2; k++) begin
			rem_n = {rem_n[30:0], sh_n[31]};
			sh_n  = {sh_n[30:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_n   = rem_n - {1'b0, den_q};
				sh_n[0] = 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign quo  = sh_q[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {3'd0, num[60:32]};
			sh_q  <= num[31:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_n;
			sh_q  <= sh_n;
		end
	end

endmodule

>>> design/lavm_core.sv
// Back end: sequenced datapath that builds the view matrix from one item.
`timescale 1ns / 1ps

module lavm_core #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  lavm_pkg::item_t   item,
	output logic              item_pop,
	output logic              put_valid,
	input  logic              put_ready,
	output lavm_pkg::matrix_t mat
);

	localparam int RD     = 30 - FRAC_BITS;
	localparam int RND_SH = (RD > 0) ? RD - 1 : 0;
	localparam int LSH    = (WORD_BITS < 32) ? 32 - WORD_BITS : 0;
	localparam logic signed [68:0] SAT_HI = (69'sd1 <<< (WORD_BITS - 1)) - 69'sd1;
	localparam logic signed [68:0] SAT_LO = -SAT_HI - 69'sd1;
	localparam logic signed [67:0] HALF_UNIT = 68'sd1 <<< 29;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NRM  = 3'd1;
	localparam logic [2:0] S_MAC  = 3'd2;
	localparam logic [2:0] S_MWT  = 3'd3;
	localparam logic [2:0] S_MST  = 3'd4;
	localparam logic [2:0] S_SQRT = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_PUT  = 3'd7;

	// product groups on the shared multiplier
	localparam logic [1:0] GRP_SQ = 2'd0;	// sum of squares
	localparam logic [1:0] GRP_T  = 2'd1;	// up x w
	localparam logic [1:0] GRP_V  = 2'd2;	// w x u
	localparam logic [1:0] GRP_X  = 2'd3;	// -(row . eye)

	localparam logic [1:0] TGT_GAZE  = 2'd0;
	localparam logic [1:0] TGT_UP    = 2'd1;
	localparam logic [1:0] TGT_CROSS = 2'd2;

	function automatic logic signed [32:0] ld(input lavm_pkg::word_t x);
		logic [31:0]        t;
		logic signed [32:0] r;
		t = x << LSH;
		r = $signed({t[31], t}) >>> LSH;
		if (WORD_BITS > 32) r = $signed({1'b0, x});
		return r;
	endfunction

	function automatic logic [32:0] mag33(input logic signed [32:0] x);
		logic [32:0] r;
		r = x[32] ? 33'(-x) : 33'(x);
		return r;
	endfunction

	function automatic lavm_pkg::word_t sat(input logic signed [68:0] x);
		logic signed [68:0] y;
		y = x;
		if (x > SAT_HI) y = SAT_HI;
		else if (x < SAT_LO) y = SAT_LO;
		return y[31:0];
	endfunction

	function automatic lavm_pkg::word_t rot(input logic signed [32:0] x);
		logic signed [68:0] e;
		e = x;
		if (RD > 0) e = (e + (69'sd1 <<< RND_SH)) >>> RD;
		return sat(e);
	endfunction

	function automatic logic [1:0] nx3(input logic [1:0] i);
		case (i)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	logic [2:0]          state_q;
	logic                deg_q;
	logic [1:0]          tgt_q;
	logic                uv_q;
	logic [1:0]          grp_q;
	logic [1:0]          cmp_q;
	logic [1:0]          idx_q;

	logic signed [32:0]  eye_q [3];
	logic signed [32:0]  up_q  [3];
	logic [61:0]         nm_q  [3];
	logic                ns_q  [3];
	logic [29:0]         cm_q  [3];
	logic                cs_q  [3];
	logic signed [30:0]  upr_q [3];
	logic signed [31:0]  w_q   [3];
	logic signed [31:0]  u_q   [3];
	logic signed [32:0]  v_q   [3];
	logic signed [61:0]  t_q   [3];
	lavm_pkg::word_t     tr_q  [3];

	logic signed [67:0]  acc_q;
	logic signed [67:0]  mul_s1;
	logic                mv_s1;
	logic                mn_s1;

	logic [61:0]         sq_n_q;
	logic [61:0]         sq_r_q;
	logic [60:0]         sq_b_q;
	logic [61:0]         sq_n_n;
	logic [61:0]         sq_r_n;
	logic [60:0]         sq_b_n;

	logic                dv_start;
	logic                dv_busy [3];
	logic [30:0]         dv_quo  [3];
	logic [60:0]         dv_num  [3];

	logic signed [33:0]  opa;
	logic signed [33:0]  opb;
	logic                opn;
	logic [1:0]          ai;
	logic [1:0]          bi;
	logic [1:0]          last_idx;
	logic                issue;

	logic signed [32:0]  ld_eye [3];
	logic signed [32:0]  ld_gz  [3];
	logic signed [32:0]  ld_up  [3];
	logic [61:0]         nm_n   [3];
	logic                nrm_done;
	logic signed [61:0]  tv     [3];
	logic                t_zero;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ld_eye[i] = ld(item.eye[i]);
			ld_gz[i]  = ld(item.gaze[i]);
			ld_up[i]  = ld(item.up[i]);
		end
	end

	// Block scaling: one coarse or fine shift a cycle until the top lies in [2^29, 2^30)
	always_comb begin
		logic hi8, hi1, lo4, lo1;
		hi8 = 1'b0;
		hi1 = 1'b0;
		lo4 = 1'b1;
		lo1 = 1'b1;
		for (int i = 0; i < 3; i++) begin
			hi8 = hi8 | (nm_q[i][61:38] != '0);
			hi1 = hi1 | (nm_q[i][61:30] != '0);
			lo4 = lo4 & (nm_q[i][61:26] == '0);
			lo1 = lo1 & (nm_q[i][61:29] == '0);
		end
		nrm_done = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (hi8) nm_n[i] = nm_q[i] >> 8;
			else if (hi1) nm_n[i] = nm_q[i] >> 1;
			else if (lo4) nm_n[i] = nm_q[i] << 4;
			else if (lo1) nm_n[i] = nm_q[i] << 1;
			else nm_n[i] = nm_q[i];
		end
		if (!hi8 && !hi1 && !lo4 && !lo1) nrm_done = 1'b1;
	end

	// Integer square root, two result bits a cycle
	always_comb begin
		sq_n_n = sq_n_q;
		sq_r_n = sq_r_q;
		sq_b_n = sq_b_q;
		for (int k = 0; k < 2; k++) begin
			if (sq_b_n != '0) begin
				if (sq_n_n >= sq_r_n + 62'(sq_b_n)) begin
					sq_n_n = sq_n_n - (sq_r_n + 62'(sq_b_n));
					sq_r_n = (sq_r_n >> 1) + 62'(sq_b_n);
				end else begin
					sq_r_n = sq_r_n >> 1;
				end
				sq_b_n = sq_b_n >> 2;
			end
		end
	end

	// Operand selection for the shared multiplier
	always_comb begin
		ai       = idx_q[0] ? nx3(nx3(cmp_q)) : nx3(cmp_q);
		bi       = idx_q[0] ? nx3(cmp_q) : nx3(nx3(cmp_q));
		last_idx = (grp_q inside {GRP_SQ, GRP_X}) ? 2'd2 : 2'd1;
		opa      = '0;
		opb      = '0;
		opn      = 1'b0;
		case (grp_q)
			GRP_SQ: begin
				opa = {4'd0, cm_q[idx_q]};
				opb = {4'd0, cm_q[idx_q]};
			end
			GRP_T: begin
				opa = upr_q[ai];
				opb = w_q[bi];
				opn = idx_q[0];
			end
			GRP_V: begin
				opa = w_q[ai];
				opb = u_q[bi];
				opn = idx_q[0];
			end
			default: begin
				case (cmp_q)
					2'd0:    opa = u_q[idx_q];
					2'd1:    opa = v_q[idx_q];
					default: opa = w_q[idx_q];
				endcase
				opb = eye_q[idx_q];
				opn = 1'b1;
			end
		endcase
	end

	assign issue = (state_q == S_MAC);

	always_comb begin
		for (int i = 0; i < 3; i++) tv[i] = (i == 2) ? acc_q[61:0] : t_q[i];
		t_zero = (t_q[0] == '0) && (t_q[1] == '0) && (acc_q[61:0] == '0);
	end

	assign dv_start = (state_q == S_SQRT) && (sq_b_q == '0);

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_div
			assign dv_num[g] = 61'({cm_q[g], 30'd0}) + 61'(sq_r_q[30:1]);
			lavm_div u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (dv_start),
				.num    (dv_num[g]),
				.den    (sq_r_q[30:0]),
				.busy   (dv_busy[g]),
				.quo    (dv_quo[g])
			);
		end
	endgenerate

	assign item_pop  = (state_q == S_IDLE) && item_valid;
	assign put_valid = (state_q == S_PUT);

	always_comb begin
		mat.degenerate = deg_q;
		for (int c = 0; c < 3; c++) begin
			mat.m[c][0] = rot(33'(u_q[c]));
			mat.m[c][1] = rot(v_q[c]);
			mat.m[c][2] = rot(33'(w_q[c]));
			mat.m[c][3] = '0;
			mat.m[3][c] = tr_q[c];
		end
		mat.m[3][3] = sat(69'sd1 <<< FRAC_BITS);
		if (deg_q) mat.m = '0;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mv_s1   <= 1'b0;
		end else begin
			mv_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.gaze_zero || item.up_zero) state_q <= S_PUT;
						else state_q <= S_NRM;
					end
				end
				S_NRM:  if (nrm_done) state_q <= S_MAC;
				S_MAC:  if (idx_q == last_idx) state_q <= S_MWT;
				S_MWT:  state_q <= S_MST;
				S_MST: begin
					case (grp_q)
						GRP_SQ:  state_q <= S_SQRT;
						GRP_T: begin
							if (cmp_q == 2'd2) state_q <= t_zero ? S_PUT : S_NRM;
							else state_q <= S_MAC;
						end
						GRP_V:   state_q <= S_MAC;
						default: state_q <= (cmp_q == 2'd2) ? S_PUT : S_MAC;
					endcase
				end
				S_SQRT: if (sq_b_q == '0) state_q <= S_DIV;
				S_DIV: begin
					if (!dv_busy[0]) state_q <= uv_q ? S_MAC : S_NRM;
				end
				S_PUT:  if (put_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (mv_s1) acc_q <= acc_q + (mn_s1 ? -mul_s1 : mul_s1);
		if (issue) begin
			mul_s1 <= opa * opb;
			mn_s1  <= opn;
			if (idx_q != last_idx) idx_q <= idx_q + 2'd1;
		end
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					deg_q <= item.gaze_zero || item.up_zero;
					tgt_q <= TGT_GAZE;
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= ld_eye[i];
						up_q[i]  <= ld_up[i];
						nm_q[i]  <= 62'(mag33(ld_gz[i]));
						ns_q[i]  <= ld_gz[i][32];
					end
				end
			end
			S_NRM: begin
				if (nrm_done) begin
					cmp_q <= 2'd0;
					idx_q <= 2'd0;
					acc_q <= '0;
					for (int i = 0; i < 3; i++) begin
						cm_q[i]  <= nm_q[i][29:0];
						cs_q[i]  <= ns_q[i];
						upr_q[i] <= ns_q[i] ? -$signed({1'b0, nm_q[i][29:0]})
							: $signed({1'b0, nm_q[i][29:0]});
					end
					case (tgt_q)
						TGT_UP:    grp_q <= GRP_T;
						TGT_CROSS: begin
							grp_q <= GRP_SQ;
							uv_q  <= 1'b1;
						end
						default: begin
							grp_q <= GRP_SQ;
							uv_q  <= 1'b0;
						end
					endcase
				end else begin
					for (int i = 0; i < 3; i++) nm_q[i] <= nm_n[i];
				end
			end
			S_MST: begin
				idx_q <= 2'd0;
				case (grp_q)
					GRP_SQ: begin
						sq_n_q <= acc_q[61:0];
						sq_r_q <= '0;
						sq_b_q <= 61'd1 << 60;
					end
					GRP_T: begin
						t_q[cmp_q] <= acc_q[61:0];
						acc_q      <= '0;
						cmp_q      <= cmp_q + 2'd1;
						if (cmp_q == 2'd2) begin
							deg_q <= t_zero;
							tgt_q <= TGT_CROSS;
							for (int i = 0; i < 3; i++) begin
								nm_q[i] <= tv[i][61] ? 62'(-tv[i]) : 62'(tv[i]);
								ns_q[i] <= tv[i][61];
							end
						end
					end
					GRP_V: begin
						v_q[cmp_q] <= acc_q[62:30];
						acc_q      <= HALF_UNIT;
						if (cmp_q == 2'd2) begin
							grp_q <= GRP_X;
							cmp_q <= 2'd0;
						end else begin
							cmp_q <= cmp_q + 2'd1;
						end
					end
					default: begin
						tr_q[cmp_q] <= sat(69'(acc_q >>> 30));
						acc_q       <= HALF_UNIT;
						cmp_q       <= cmp_q + 2'd1;
					end
				endcase
			end
			S_SQRT: begin
				sq_n_q <= sq_n_n;
				sq_r_q <= sq_r_n;
				sq_b_q <= sq_b_n;
			end
			S_DIV: begin
				if (!dv_busy[0]) begin
					for (int i = 0; i < 3; i++) begin
						if (uv_q) begin
							u_q[i] <= cs_q[i] ? -$signed({1'b0, dv_quo[i]})
								: $signed({1'b0, dv_quo[i]});
						end else begin
							// w is the negated unit gaze
							w_q[i] <= cs_q[i] ? $signed({1'b0, dv_quo[i]})
								: -$signed({1'b0, dv_quo[i]});
							nm_q[i] <= 62'(mag33(up_q[i]));
							ns_q[i] <= up_q[i][32];
						end
					end
					tgt_q <= TGT_UP;
					grp_q <= GRP_V;
					cmp_q <= 2'd0;
					idx_q <= 2'd0;
					acc_q <= HALF_UNIT;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/lavm_emit.sv
// Output stage: holds one finished matrix and hands it out a column at a time.
`timescale 1ns / 1ps

module lavm_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              put_valid,
	output logic              put_ready,
	input  lavm_pkg::matrix_t mat,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        column_index,
	output lavm_pkg::word_t   row0_value,
	output lavm_pkg::word_t   row1_value,
	output lavm_pkg::word_t   row2_value,
	output lavm_pkg::word_t   row3_value,
	output logic              last_column,
	output logic              degenerate
);

	lavm_pkg::matrix_t mat_q;
	logic              full_q;
	logic [1:0]        col_q;
	logic              xfer;
	logic              load;

	assign xfer      = full_q && !out_stall;
	assign put_ready = !full_q || (xfer && col_q == 2'd3);
	assign load      = put_valid && put_ready;

	assign out_valid    = full_q;
	assign column_index = col_q;
	assign row0_value   = mat_q.m[col_q][0];
	assign row1_value   = mat_q.m[col_q][1];
	assign row2_value   = mat_q.m[col_q][2];
	assign row3_value   = mat_q.m[col_q][3];
	assign last_column  = (col_q == 2'd3);
	assign degenerate   = mat_q.degenerate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			col_q  <= 2'd0;
		end else if (load) begin
			full_q <= 1'b1;
			col_q  <= 2'd0;
		end else if (xfer) begin
			col_q <= col_q + 2'd1;
			if (col_q == 2'd3) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) mat_q <= mat;
	end

endmodule

>>> design/look_at_view_matrix_top.sv
// Top level of the look-at view matrix block.
`timescale 1ns / 1ps

// Look-at view matrix. Each accepted transfer carries eye, gaze and up vectors
// in signed fixed point; the block answers with four transfers, columns 0 to 3
// of the column-major view matrix (rows u, v, w with their translations, then
// 0 0 0 1), last_column set on the fourth. A zero gaze, a zero up vector or up
// parallel to gaze gives all-zero columns with degenerate set. In the core a normal
// item uses the single shared 34x34 multiplier (27 products, one a cycle, plus
// a drain and a store state per sum), two square roots and two rounds of three
// parallel dividers, each resolving two bits a cycle. What varies with the item
// is the block scaling of gaze, up and up x w, one shift a cycle. A degenerate
// gaze or up vector skips the datapath and goes straight to the output. The
// front register and a two-entry queue take further items while the core works,
// and the output register releases the core as soon as it holds a matrix.
module look_at_view_matrix_top #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lavm_pkg::word_t eye_x,
	input  lavm_pkg::word_t eye_y,
	input  lavm_pkg::word_t eye_z,
	input  lavm_pkg::word_t gaze_x,
	input  lavm_pkg::word_t gaze_y,
	input  lavm_pkg::word_t gaze_z,
	input  lavm_pkg::word_t up_x,
	input  lavm_pkg::word_t up_y,
	input  lavm_pkg::word_t up_z,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      column_index,
	output lavm_pkg::word_t row0_value,
	output lavm_pkg::word_t row1_value,
	output lavm_pkg::word_t row2_value,
	output lavm_pkg::word_t row3_value,
	output logic            last_column,
	output logic            degenerate
);

	logic              push;
	lavm_pkg::item_t   push_item;
	logic              q_full;
	logic              q_valid;
	lavm_pkg::item_t   q_item;
	logic              q_pop;
	logic              put_valid;
	logic              put_ready;
	lavm_pkg::matrix_t mat;

	// front: registers the transfer and flags zero vectors
	lavm_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.eye_x     (eye_x),
		.eye_y     (eye_y),
		.eye_z     (eye_z),
		.gaze_x    (gaze_x),
		.gaze_y    (gaze_y),
		.gaze_z    (gaze_z),
		.up_x      (up_x),
		.up_y      (up_y),
		.up_z      (up_z),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	lavm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_item  (q_item),
		.pop       (q_pop)
	);

	// core: normalise, cross products, translations
	lavm_core #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.item_pop   (q_pop),
		.put_valid  (put_valid),
		.put_ready  (put_ready),
		.mat        (mat)
	);

	lavm_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.put_valid    (put_valid),
		.put_ready    (put_ready),
		.mat          (mat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.column_index (column_index),
		.row0_value   (row0_value),
		.row1_value   (row1_value),
		.row2_value   (row2_value),
		.row3_value   (row3_value),
		.last_column  (last_column),
		.degenerate   (degenerate)
	);

endmodule

>>> tb/look_at_view_matrix_top_test.sv
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 1ps

module look_at_view_matrix_top_test;

	localparam int FRAC = 16;
	localparam int WBITS = 32;
	localparam int UNIT = 30;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [31:0] eye [3];
		logic [31:0] gaze [3];
		logic [31:0] up [3];
	} camera_t;

	typedef struct {
		logic [1:0]  col;
		logic [31:0] r0, r1, r2, r3;
		logic        last;
		logic        degen;
	} column_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic in_fire = 1'b0;
	lavm_pkg::word_t eye_x = '0, eye_y = '0, eye_z = '0;
	lavm_pkg::word_t gaze_x = '0, gaze_y = '0, gaze_z = '0;
	lavm_pkg::word_t up_x = '0, up_y = '0, up_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] column_index;
	lavm_pkg::word_t row0_value, row1_value, row2_value, row3_value;
	logic last_column, degenerate;

	look_at_view_matrix_top #(.FRAC_BITS(FRAC), .WORD_BITS(WBITS)) dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	camera_t pending_cams[$];
	column_t expected_cols[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	// ---- matrix prediction ----

	function automatic longint unsigned magn(longint x);
		return x < 0 ? longint'(0) - x : x;
	endfunction

	function automatic longint unsigned sqrt_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// scale so the largest magnitude lands in [2^29, 2^30); 0 when all zero
	function automatic bit normalise_block(input longint a [3], output longint o [3]);
		longint unsigned m [3];
		longint unsigned top;
		int s, l;
		longint v;
		top = 0;
		s = 0;
		l = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magn(a[i]);
			if (m[i] > top) top = m[i];
		end
		o = '{0, 0, 0};
		if (top == 0) return 0;
		while ((top >> s) >= (64'd1 << 30)) s++;
		while ((top << l) < (64'd1 << 29)) l++;
		for (int i = 0; i < 3; i++) begin
			v = longint'((m[i] >> s) << l);
			o[i] = a[i] < 0 ? -v : v;
		end
		return 1;
	endfunction

	function automatic bit unit_of(input longint a [3], output longint o [3]);
		longint c [3];
		longint unsigned n2, n, q;
		o = '{0, 0, 0};
		if (!normalise_block(a, c)) return 0;
		n2 = 0;
		for (int i = 0; i < 3; i++) n2 += magn(c[i]) * magn(c[i]);
		n = sqrt_floor(n2);
		for (int i = 0; i < 3; i++) begin
			q = ((magn(c[i]) << UNIT) + n / 2) / n;
			o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void cross_of(input longint a [3], input longint b [3],
		output longint o [3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic logic [31:0] clamp_word(logic signed [127:0] x);
		if (x > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
		if (x < -128'sh80000000) return 32'h80000000;
		return x[31:0];
	endfunction

	function automatic logic [31:0] offset_of(input longint r [3], input longint e [3]);
		logic signed [127:0] acc;
		acc = 128'sd1 <<< (UNIT - 1);
		for (int i = 0; i < 3; i++)
			acc += -(128'(signed'(r[i])) * 128'(signed'(e[i])));
		return clamp_word(acc >>> UNIT);
	endfunction

	function automatic logic [31:0] rotation_elem(longint x);
		logic signed [127:0] t;
		t = (128'(signed'(x)) + (128'sd1 <<< (UNIT - FRAC - 1))) >>> (UNIT - FRAC);
		return clamp_word(t);
	endfunction

	task automatic queue_view_matrix(camera_t c);
		longint eye [3], gaze [3], up [3], ups [3], w [3], u [3], v [3], t [3];
		logic [31:0] m [4][4];
		bit ok;
		column_t col;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'(signed'(c.eye[i]));
			gaze[i] = longint'(signed'(c.gaze[i]));
			up[i] = longint'(signed'(c.up[i]));
		end
		for (int r = 0; r < 4; r++)
			for (int k = 0; k < 4; k++) m[r][k] = '0;
		ok = unit_of(gaze, w);
		if (ok) begin
			for (int i = 0; i < 3; i++) w[i] = -w[i];
			ok = normalise_block(up, ups);
		end
		if (ok) begin
			cross_of(ups, w, t);
			ok = unit_of(t, u);
		end
		if (ok) begin
			cross_of(w, u, t);
			for (int i = 0; i < 3; i++)
				v[i] = (t[i] + (64'sd1 <<< (UNIT - 1))) >>> UNIT;
			for (int k = 0; k < 3; k++) begin
				m[0][k] = rotation_elem(u[k]);
				m[1][k] = rotation_elem(v[k]);
				m[2][k] = rotation_elem(w[k]);
			end
			m[0][3] = offset_of(u, eye);
			m[1][3] = offset_of(v, eye);
			m[2][3] = offset_of(w, eye);
			m[3][3] = clamp_word(128'sd1 <<< FRAC);
		end
		for (int k = 0; k < 4; k++) begin
			col.col = k[1:0];
			col.r0 = m[0][k];
			col.r1 = m[1][k];
			col.r2 = m[2][k];
			col.r3 = m[3][k];
			col.last = (k == 3);
			col.degen = !ok;
			expected_cols.push_back(col);
		end
	endtask

	// input transfer seen at the rising edge, for the driver at the next falling edge
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
	end

	// ---- driver: presents queued cameras, prediction made on each transfer ----
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire)
				queue_view_matrix(pending_cams.pop_front());
			// hold a stalled transfer; otherwise maybe present the next camera
			if (!(in_valid && !in_fire)) begin
				if (pending_cams.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					eye_x <= pending_cams[0].eye[0];
					eye_y <= pending_cams[0].eye[1];
					eye_z <= pending_cams[0].eye[2];
					gaze_x <= pending_cams[0].gaze[0];
					gaze_y <= pending_cams[0].gaze[1];
					gaze_z <= pending_cams[0].gaze[2];
					up_x <= pending_cams[0].up[0];
					up_y <= pending_cams[0].up[1];
					up_z <= pending_cams[0].up[2];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---- monitor: compare each column transfer against the oldest prediction ----
	always @(posedge clk) begin
		column_t e;
		if (arst_n) begin
			quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall))
				? 0 : quiet_cycles + 1;
			if (out_valid && !out_stall) begin
				if (expected_cols.size() == 0) begin
					$error("unexpected column transfer, column %0d", column_index);
					errors++;
				end else begin
					e = expected_cols.pop_front();
					if (column_index !== e.col) begin
						$error("column_index: expected %0d, got %0d", e.col, column_index);
						errors++;
					end
					if (row0_value !== e.r0) begin
						$error("row0_value: expected %h, got %h", e.r0, row0_value);
						errors++;
					end
					if (row1_value !== e.r1) begin
						$error("row1_value: expected %h, got %h", e.r1, row1_value);
						errors++;
					end
					if (row2_value !== e.r2) begin
						$error("row2_value: expected %h, got %h", e.r2, row2_value);
						errors++;
					end
					if (row3_value !== e.r3) begin
						$error("row3_value: expected %h, got %h", e.r3, row3_value);
						errors++;
					end
					if (last_column !== e.last) begin
						$error("last_column: expected %0d, got %0d", e.last, last_column);
						errors++;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate: expected %0d, got %0d", e.degen, degenerate);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on progress
	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---- stimulus ----

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return $urandom_range(1) ? 32'h0 : 32'h1;
			default: return 32'(signed'($urandom_range(0, 64)) - 32) <<< FRAC;
		endcase
	endfunction

	function automatic camera_t rand_camera();
		camera_t c;
		int mode;
		int k;
		mode = $urandom_range(19);
		for (int i = 0; i < 3; i++) begin
			c.eye[i] = rand_word();
			c.gaze[i] = rand_word();
			c.up[i] = rand_word();
		end
		if (mode == 0) c.gaze = '{0, 0, 0};
		else if (mode == 1) c.up = '{0, 0, 0};
		else if (mode == 2) begin
			// up as a scaled, reversed copy of gaze: parallel case
			k = $urandom_range(1, 3);
			for (int i = 0; i < 3; i++)
				c.up[i] = 32'(-($signed(c.gaze[i]) >>> k));
			if ($urandom_range(1)) c.gaze = '{c.up[0], c.up[1], c.up[2]};
		end
		return c;
	endfunction

	function automatic camera_t mk(logic [31:0] ex, ey, ez, gx, gy, gz, ux, uy, uz);
		camera_t c;
		c.eye = '{ex, ey, ez};
		c.gaze = '{gx, gy, gz};
		c.up = '{ux, uy, uz};
		return c;
	endfunction

	task automatic drain();
		while (pending_cams.size() != 0 || in_valid || expected_cols.size() != 0)
			@(posedge clk);
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
	localparam logic [31:0] MINW = 32'h8000_0000;

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: plain frames, extremes, and each degenerate case
		send_idle_pct = 37;
		recv_idle_pct = 77;
		pending_cams.push_back(mk(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
		pending_cams.push_back(mk(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, 0, ONE, 0));
		pending_cams.push_back(mk(MAXW, MAXW, MAXW, ONE, ONE, ONE, 0, 0, ONE));
		pending_cams.push_back(mk(MINW, MINW, MINW, -ONE, -ONE, -ONE, 0, 0, ONE));
		pending_cams.push_back(mk(MAXW, MINW, MAXW, MAXW, MINW, 1, MINW, MAXW, 0));
		pending_cams.push_back(mk(MINW, MAXW, MINW, MINW, MINW, MINW, MAXW, 0, MAXW));
		pending_cams.push_back(mk(ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0));
		pending_cams.push_back(mk(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
		pending_cams.push_back(mk(0, 0, 0, 0, 0, ONE, 0, 0, 0));
		pending_cams.push_back(mk(0, 0, 0, 0, ONE, 0, 0, 5 * ONE, 0));
		pending_cams.push_back(mk(0, 0, 0, ONE, ONE, 0, -3, -3, 0));
		pending_cams.push_back(mk(5, 7, 9, 1, 0, 0, 0, 1, 0));
		pending_cams.push_back(mk(32'hFFFFFFFF, 0, 1, 0, 1, 1, 1, 0, 0));
		pending_cams.push_back(mk(32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF,
			32'h55555555, 32'hAAAAAAAA, 32'h12345678,
			32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF));
		// hold off until every column has arrived
		drain();

		for (int i = 0; i < 120; i++) pending_cams.push_back(rand_camera());
		drain();
		send_idle_pct = 77;
		recv_idle_pct = 37;
		for (int i = 0; i < 120; i++) pending_cams.push_back(rand_camera());
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 120; i++) pending_cams.push_back(rand_camera());
		drain();

		repeat (400) @(posedge clk);
		if (errors == 0 && expected_cols.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
design/lavm_pkg.sv
design/lavm_front.sv
design/lavm_fifo.sv
design/lavm_div.sv
design/lavm_core.sv
design/lavm_emit.sv
design/look_at_view_matrix_top.sv
tb/look_at_view_matrix_top_test.sv
